### rtl/gpbb_pkg.sv
// ----------------------------------------------------------------------------
// gpbb_pkg
// shared types and constants for the green point bounding box block
// ----------------------------------------------------------------------------
`default_nettype none

package gpbb_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COLOR_BITS     = 8;
    localparam int CFG_IDX_BITS   = 3;

    // configuration register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_X_LOWER      = 3'd0,
        REG_X_UPPER      = 3'd1,
        REG_Y_LOWER      = 3'd2,
        REG_Y_UPPER      = 3'd3,
        REG_Z_LOWER      = 3'd4,
        REG_Z_UPPER      = 3'd5,
        REG_GREEN_FLOOR  = 3'd6,
        REG_GREEN_MARGIN = 3'd7
    } cfg_reg_t;

    // register reset values
    localparam int X_LOWER_RESET = -500;
    localparam int X_UPPER_RESET = 500;
    localparam int Y_LOWER_RESET = -1000;
    localparam int Y_UPPER_RESET = 1000;
    localparam int Z_LOWER_RESET = 0;
    localparam int Z_UPPER_RESET = 2000;

    localparam logic [COLOR_BITS-1:0] GREEN_FLOOR_RESET  = 8'd127;
    localparam logic [COLOR_BITS-1:0] GREEN_MARGIN_RESET = 8'd50;

    // reported color extrema of an empty cloud
    localparam logic [COLOR_BITS-1:0] COLOR_MIN_EMPTY = 8'd255;
    localparam logic [COLOR_BITS-1:0] COLOR_MAX_EMPTY = 8'd0;

    // color features of one point
    typedef struct packed {
        logic [COLOR_BITS-1:0] blue_gap;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] red_gap;
    } color_t;

    // point stage status toward the accumulator
    typedef struct packed {
        logic valid;
        logic counted;
        logic last;
    } pt_ctl_t;

endpackage

`default_nettype wire

### rtl/gpbb_cfg.sv
// ----------------------------------------------------------------------------
// gpbb_cfg
// workspace limits and green thresholds, written through the config channel
// ----------------------------------------------------------------------------
`default_nettype none

module gpbb_cfg #(
    parameter int COORD_BITS = gpbb_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [gpbb_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [COORD_BITS-1:0]             cfg_data,
    output logic signed [COORD_BITS-1:0]           x_lower,
    output logic signed [COORD_BITS-1:0]           x_upper,
    output logic signed [COORD_BITS-1:0]           y_lower,
    output logic signed [COORD_BITS-1:0]           y_upper,
    output logic signed [COORD_BITS-1:0]           z_lower,
    output logic signed [COORD_BITS-1:0]           z_upper,
    output logic [gpbb_pkg::COLOR_BITS-1:0]        green_floor,
    output logic [gpbb_pkg::COLOR_BITS-1:0]        green_margin
);
    import gpbb_pkg::*;

    logic signed [COORD_BITS-1:0] x_lower_reg, x_upper_reg;
    logic signed [COORD_BITS-1:0] y_lower_reg, y_upper_reg;
    logic signed [COORD_BITS-1:0] z_lower_reg, z_upper_reg;
    logic [COLOR_BITS-1:0]        floor_reg, margin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lower_reg <= COORD_BITS'(X_LOWER_RESET);
            x_upper_reg <= COORD_BITS'(X_UPPER_RESET);
            y_lower_reg <= COORD_BITS'(Y_LOWER_RESET);
            y_upper_reg <= COORD_BITS'(Y_UPPER_RESET);
            z_lower_reg <= COORD_BITS'(Z_LOWER_RESET);
            z_upper_reg <= COORD_BITS'(Z_UPPER_RESET);
            floor_reg   <= GREEN_FLOOR_RESET;
            margin_reg  <= GREEN_MARGIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_X_LOWER:      x_lower_reg <= cfg_data;
                REG_X_UPPER:      x_upper_reg <= cfg_data;
                REG_Y_LOWER:      y_lower_reg <= cfg_data;
                REG_Y_UPPER:      y_upper_reg <= cfg_data;
                REG_Z_LOWER:      z_lower_reg <= cfg_data;
                REG_Z_UPPER:      z_upper_reg <= cfg_data;
                REG_GREEN_FLOOR:  floor_reg   <= cfg_data[COLOR_BITS-1:0];
                REG_GREEN_MARGIN: margin_reg  <= cfg_data[COLOR_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign x_lower      = x_lower_reg;
    assign x_upper      = x_upper_reg;
    assign y_lower      = y_lower_reg;
    assign y_upper      = y_upper_reg;
    assign z_lower      = z_lower_reg;
    assign z_upper      = z_upper_reg;
    assign green_floor  = floor_reg;
    assign green_margin = margin_reg;

endmodule

`default_nettype wire

### rtl/gpbb_point.sv
// ----------------------------------------------------------------------------
// gpbb_point
// input register and point qualification (workspace box and green test)
// ----------------------------------------------------------------------------
`default_nettype none

module gpbb_point #(
    parameter int COORD_BITS = gpbb_pkg::COORD_BITS_DEF,
    parameter int IN_W       = 8 * ((3 * COORD_BITS + 3 * gpbb_pkg::COLOR_BITS + 7) / 8)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [IN_W-1:0]             s_tdata,
    input  wire logic                        s_tuser,
    input  wire logic                        s_tlast,
    input  wire logic                        advance,
    input  wire logic signed [COORD_BITS-1:0] x_lower,
    input  wire logic signed [COORD_BITS-1:0] x_upper,
    input  wire logic signed [COORD_BITS-1:0] y_lower,
    input  wire logic signed [COORD_BITS-1:0] y_upper,
    input  wire logic signed [COORD_BITS-1:0] z_lower,
    input  wire logic signed [COORD_BITS-1:0] z_upper,
    input  wire logic [gpbb_pkg::COLOR_BITS-1:0] green_floor,
    input  wire logic [gpbb_pkg::COLOR_BITS-1:0] green_margin,
    output gpbb_pkg::pt_ctl_t                pt_ctl,
    output logic signed [COORD_BITS-1:0]     pos_x,
    output logic signed [COORD_BITS-1:0]     pos_y,
    output logic signed [COORD_BITS-1:0]     pos_z,
    output gpbb_pkg::color_t                 pt_color
);
    import gpbb_pkg::*;

    localparam int RED_LSB   = 3 * COORD_BITS;
    localparam int GREEN_LSB = RED_LSB + COLOR_BITS;
    localparam int BLUE_LSB  = GREEN_LSB + COLOR_BITS;

    logic                         valid_reg, valid_next;
    logic signed [COORD_BITS-1:0] x_reg, y_reg, z_reg;
    logic [COLOR_BITS-1:0]        red_reg, green_reg, blue_reg;
    logic                         ok_reg, last_reg;
    logic                         load;
    logic                         in_box, is_green;
    logic [COLOR_BITS:0]          red_bar, blue_bar;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg     <= s_tdata[COORD_BITS-1:0];
            y_reg     <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            z_reg     <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
            red_reg   <= s_tdata[RED_LSB +: COLOR_BITS];
            green_reg <= s_tdata[GREEN_LSB +: COLOR_BITS];
            blue_reg  <= s_tdata[BLUE_LSB +: COLOR_BITS];
            ok_reg    <= s_tuser;
            last_reg  <= s_tlast;
        end
    end

    // inclusive box test, inverted limits pass nothing
    assign in_box = (x_reg >= x_lower) && (x_reg <= x_upper)
                 && (y_reg >= y_lower) && (y_reg <= y_upper)
                 && (z_reg >= z_lower) && (z_reg <= z_upper);

    // thresholds one bit wider so they cannot wrap
    assign red_bar  = {1'b0, red_reg} + {1'b0, green_margin};
    assign blue_bar = {1'b0, blue_reg} + {1'b0, green_margin};

    assign is_green = (green_reg > green_floor)
                   && ({1'b0, green_reg} > red_bar)
                   && ({1'b0, green_reg} > blue_bar);

    assign pt_ctl.valid   = valid_reg;
    assign pt_ctl.counted = ok_reg && in_box && is_green;
    assign pt_ctl.last    = last_reg;

    assign pos_x = x_reg;
    assign pos_y = y_reg;
    assign pos_z = z_reg;

    // gaps only matter for counted points, where green exceeds both
    assign pt_color.red_gap  = green_reg - red_reg;
    assign pt_color.green    = green_reg;
    assign pt_color.blue_gap = green_reg - blue_reg;

endmodule

`default_nettype wire

### rtl/gpbb_accum.sv
// ----------------------------------------------------------------------------
// gpbb_accum
// running extrema of counted points and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module gpbb_accum #(
    parameter int COORD_BITS = gpbb_pkg::COORD_BITS_DEF,
    parameter int OUT_W      = 8 * ((6 * COORD_BITS + 6 * gpbb_pkg::COLOR_BITS + 7) / 8)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gpbb_pkg::pt_ctl_t            pt_ctl,
    input  wire logic signed [COORD_BITS-1:0] pos_x,
    input  wire logic signed [COORD_BITS-1:0] pos_y,
    input  wire logic signed [COORD_BITS-1:0] pos_z,
    input  wire gpbb_pkg::color_t             pt_color,
    input  wire logic signed [COORD_BITS-1:0] x_lower,
    input  wire logic signed [COORD_BITS-1:0] x_upper,
    input  wire logic signed [COORD_BITS-1:0] y_lower,
    input  wire logic signed [COORD_BITS-1:0] y_upper,
    input  wire logic signed [COORD_BITS-1:0] z_lower,
    input  wire logic signed [COORD_BITS-1:0] z_upper,
    output logic                              advance,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [OUT_W-1:0]                  m_tdata
);
    import gpbb_pkg::*;

    localparam int RES_W = 6 * COORD_BITS + 6 * COLOR_BITS;

    logic                         seen_reg, seen_next, seen_upd;
    logic signed [COORD_BITS-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg, zmin_reg, zmax_reg;
    logic signed [COORD_BITS-1:0] xmin_next, xmax_next, ymin_next, ymax_next;
    logic signed [COORD_BITS-1:0] zmin_next, zmax_next;
    logic signed [COORD_BITS-1:0] xmin_upd, xmax_upd, ymin_upd, ymax_upd, zmin_upd, zmax_upd;
    color_t                       cmin_reg, cmax_reg, cmin_next, cmax_next, cmin_upd, cmax_upd;
    logic                         out_valid_reg, out_valid_next;
    logic [RES_W-1:0]             res_reg, res_next;
    logic                         emit;

    // a point leaves the input register unless it is a cloud end facing an unread full slot
    assign advance = pt_ctl.valid && (!pt_ctl.last || !out_valid_reg || m_tready);
    assign emit    = advance && pt_ctl.last;

    always_comb
    begin
        seen_upd = seen_reg;
        xmin_upd = xmin_reg;
        xmax_upd = xmax_reg;
        ymin_upd = ymin_reg;
        ymax_upd = ymax_reg;
        zmin_upd = zmin_reg;
        zmax_upd = zmax_reg;
        cmin_upd = cmin_reg;
        cmax_upd = cmax_reg;

        if (pt_ctl.counted)
        begin
            seen_upd = 1'b1;
            if (!seen_reg)
            begin
                // first counted point of the cloud loads directly
                xmin_upd = pos_x;
                xmax_upd = pos_x;
                ymin_upd = pos_y;
                ymax_upd = pos_y;
                zmin_upd = pos_z;
                zmax_upd = pos_z;
                cmin_upd = pt_color;
                cmax_upd = pt_color;
            end
            else
            begin
                if (pos_x < xmin_reg) xmin_upd = pos_x;
                if (pos_x > xmax_reg) xmax_upd = pos_x;
                if (pos_y < ymin_reg) ymin_upd = pos_y;
                if (pos_y > ymax_reg) ymax_upd = pos_y;
                if (pos_z < zmin_reg) zmin_upd = pos_z;
                if (pos_z > zmax_reg) zmax_upd = pos_z;
                if (pt_color.red_gap < cmin_reg.red_gap)   cmin_upd.red_gap  = pt_color.red_gap;
                if (pt_color.red_gap > cmax_reg.red_gap)   cmax_upd.red_gap  = pt_color.red_gap;
                if (pt_color.green < cmin_reg.green)       cmin_upd.green    = pt_color.green;
                if (pt_color.green > cmax_reg.green)       cmax_upd.green    = pt_color.green;
                if (pt_color.blue_gap < cmin_reg.blue_gap) cmin_upd.blue_gap = pt_color.blue_gap;
                if (pt_color.blue_gap > cmax_reg.blue_gap) cmax_upd.blue_gap = pt_color.blue_gap;
            end
        end

        // empty cloud reports the limits that are current now
        if (seen_upd)
            res_next = {cmax_upd.blue_gap, cmin_upd.blue_gap,
                        cmax_upd.green, cmin_upd.green,
                        cmax_upd.red_gap, cmin_upd.red_gap,
                        zmax_upd, zmin_upd, ymax_upd, ymin_upd, xmax_upd, xmin_upd};
        else
            res_next = {COLOR_MAX_EMPTY, COLOR_MIN_EMPTY,
                        COLOR_MAX_EMPTY, COLOR_MIN_EMPTY,
                        COLOR_MAX_EMPTY, COLOR_MIN_EMPTY,
                        z_lower, z_upper, y_lower, y_upper, x_lower, x_upper};

        if (advance)
        begin
            seen_next = emit ? 1'b0 : seen_upd;
            xmin_next = xmin_upd;
            xmax_next = xmax_upd;
            ymin_next = ymin_upd;
            ymax_next = ymax_upd;
            zmin_next = zmin_upd;
            zmax_next = zmax_upd;
            cmin_next = cmin_upd;
            cmax_next = cmax_upd;
        end
        else
        begin
            seen_next = seen_reg;
            xmin_next = xmin_reg;
            xmax_next = xmax_reg;
            ymin_next = ymin_reg;
            ymax_next = ymax_reg;
            zmin_next = zmin_reg;
            zmax_next = zmax_reg;
            cmin_next = cmin_reg;
            cmax_next = cmax_reg;
        end

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xmin_reg <= xmin_next;
        xmax_reg <= xmax_next;
        ymin_reg <= ymin_next;
        ymax_reg <= ymax_next;
        zmin_reg <= zmin_next;
        zmax_reg <= zmax_next;
        cmin_reg <= cmin_next;
        cmax_reg <= cmax_next;
        if (emit)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(res_reg);

endmodule

`default_nettype wire

### rtl/green_point_bounding_box_top.sv
// ----------------------------------------------------------------------------
// green_point_bounding_box_top
// bounding box and color extrema of green points inside a workspace box
// ----------------------------------------------------------------------------
// result: a cloud-end word goes from the input register into the result register
// throughput: 1 point word per cycle, set by the input register and the
//   accumulator update; a cloud-end word stalls only while the previous
//   result still waits on m_tready
// reset: rst_n clears the pipeline, empties the cloud and restores register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module green_point_bounding_box_top #(
    parameter int COORD_BITS = gpbb_pkg::COORD_BITS_DEF,
    parameter int IN_W       = 8 * ((3 * COORD_BITS + 3 * gpbb_pkg::COLOR_BITS + 7) / 8),
    parameter int OUT_W      = 8 * ((6 * COORD_BITS + 6 * gpbb_pkg::COLOR_BITS + 7) / 8)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // point stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // pos_x, pos_y, pos_z, red, green, blue, zero fill
    input  wire logic [IN_W-1:0]                   s_tdata,
    // point_ok
    input  wire logic                              s_tuser,
    // last_point
    input  wire logic                              s_tlast,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // box_x_min, box_x_max, box_y_min, box_y_max, box_z_min, box_z_max,
    // red_gap_min, red_gap_max, green_min, green_max, blue_gap_min,
    // blue_gap_max, zero fill
    output logic [OUT_W-1:0]                       m_tdata,
    // register writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gpbb_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [COORD_BITS-1:0]             cfg_data
);
    import gpbb_pkg::*;

    logic signed [COORD_BITS-1:0] x_lower, x_upper, y_lower, y_upper, z_lower, z_upper;
    logic [COLOR_BITS-1:0]        green_floor, green_margin;
    pt_ctl_t                      pt_ctl;
    logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z;
    color_t                       pt_color;
    logic                         advance;

    // register writes are always accepted and take effect in the next cycle
    assign cfg_ready = 1'b1;

    // workspace limits and green thresholds
    gpbb_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .x_lower      (x_lower),
        .x_upper      (x_upper),
        .y_lower      (y_lower),
        .y_upper      (y_upper),
        .z_lower      (z_lower),
        .z_upper      (z_upper),
        .green_floor  (green_floor),
        .green_margin (green_margin)
    );

    // stage one: register the word and decide whether the point counts
    gpbb_point #(
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W)
    ) u_point (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .advance      (advance),
        .x_lower      (x_lower),
        .x_upper      (x_upper),
        .y_lower      (y_lower),
        .y_upper      (y_upper),
        .z_lower      (z_lower),
        .z_upper      (z_upper),
        .green_floor  (green_floor),
        .green_margin (green_margin),
        .pt_ctl       (pt_ctl),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .pt_color     (pt_color)
    );

    // stage two: fold the point into the extrema, emit on cloud end
    gpbb_accum #(
        .COORD_BITS (COORD_BITS),
        .OUT_W      (OUT_W)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt_ctl   (pt_ctl),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .pt_color (pt_color),
        .x_lower  (x_lower),
        .x_upper  (x_upper),
        .y_lower  (y_lower),
        .y_upper  (y_upper),
        .z_lower  (z_lower),
        .z_upper  (z_upper),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
